>>> src/tted_pkg.sv
package tted_pkg;

    // Page geometry.
    localparam int unsigned PAGE_WIDTH  = 40;
    localparam int unsigned PAGE_HEIGHT = 25;

    // Field widths.
    localparam int unsigned ROW_W     = 5;
    localparam int unsigned COL_W     = 6;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned TRIPLET_W = 18;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned MODE_W    = 5;
    localparam int unsigned DATA_W    = 7;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic REG_CHARSET = 1'b0;

    // Command codes.
    localparam logic CMD_PAGE_START = 1'b0;
    localparam logic CMD_TRIPLET    = 1'b1;

    // Triplet decoding constants.
    localparam logic [10:0]       FILLER_PATTERN = 11'h7FF;
    localparam logic [ADDR_W-1:0] ROW_ADDR_BASE  = 6'd40;
    localparam logic [ADDR_W-1:0] ROW_ADDR_LAST  = 6'd63;
    localparam logic [ROW_W-1:0]  ROW_BOTTOM     = 5'd24;
    localparam logic [MODE_W-1:0] MODE_SET_ROW_A = 5'd1;
    localparam logic [MODE_W-1:0] MODE_SET_ROW_B = 5'd4;
    localparam logic [MODE_W-1:0] MODE_ROW_HOME  = 5'd7;
    localparam logic [MODE_W-1:0] MODE_G2        = 5'd15;
    localparam logic [DATA_W-1:0] G2_FIRST_CODE  = 7'd32;

    typedef struct packed {
        logic                 cmd;
        logic [TRIPLET_W-1:0] triplet;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_code;
    } result_t;

    // Control produced by the decoder for one triplet.
    typedef struct packed {
        logic             row_we;
        logic [ROW_W-1:0] row_val;
        logic             wr;
    } dec_ctl_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  l1;
        logic [7:0]  l2;
    } mark_hit_t;

    // G2 supplementary set, indexed by code minus 32.
    localparam logic [7:0] G2_L1 [96] = '{
        8'h20,8'hA1,8'hA2,8'hA3,8'h24,8'hA5,8'h23,8'hA7,
        8'hA4,8'h27,8'h22,8'hAB,8'h20,8'h20,8'h20,8'h20,
        8'hB0,8'hB1,8'hB2,8'hB3,8'hD7,8'hB5,8'hB6,8'hB7,
        8'hF7,8'h27,8'h22,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,
        8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'h20,8'h20,
        8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'h22,8'h20,8'h20,
        8'h5F,8'hB9,8'hAE,8'hA9,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'hC6,8'hD0,8'hAA,8'h48,8'h20,8'h49,8'h4C,
        8'h4C,8'hD8,8'h20,8'hBA,8'hDE,8'h54,8'h4E,8'h6E,
        8'h4B,8'hE6,8'h64,8'hF0,8'h68,8'h69,8'h69,8'h6C,
        8'h6C,8'hF8,8'h20,8'hDF,8'hFE,8'h74,8'h6E,8'h7F
    };

    localparam logic [7:0] G2_L2 [96] = '{
        8'h20,8'h69,8'h63,8'h4C,8'h24,8'h59,8'h23,8'hA7,
        8'hA4,8'h27,8'h22,8'h3C,8'h20,8'h20,8'h20,8'h20,
        8'hB0,8'h20,8'h20,8'h20,8'hD7,8'h75,8'h20,8'h20,
        8'hF7,8'h27,8'h22,8'h3E,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'hA2,8'hFF,
        8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'hBD,8'hB2,8'hB7,
        8'h2D,8'h20,8'h52,8'h43,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'hD0,8'h61,8'h48,8'h20,8'h69,8'h4C,
        8'hA3,8'h4F,8'h20,8'h6F,8'h70,8'h54,8'h4E,8'h6E,
        8'h4B,8'h20,8'hF0,8'h64,8'h68,8'h69,8'h69,8'h6C,
        8'hB3,8'h6F,8'h20,8'hDF,8'h70,8'h74,8'h6E,8'h7F
    };

    // Diacritical mark table: returns the Latin-1 and Latin-2 bytes for a
    // G0 character under a mark, with hit low where the pair is not listed.
    function automatic mark_hit_t mark_lookup(input logic [3:0] mark,
                                              input logic [6:0] g0);
        mark_hit_t r;
        r = '{hit: 1'b1, l1: 8'h00, l2: 8'h00};
        case ({mark, g0})
            {4'd0, 7'h23}:  begin r.l1 = 8'hA4; r.l2 = 8'h24; end
            {4'd1, 7'h20}:  begin r.l1 = 8'h60; r.l2 = 8'h60; end
            {4'd1, 7'h61}:  begin r.l1 = 8'hE0; r.l2 = 8'h61; end
            {4'd1, 7'h65}:  begin r.l1 = 8'hE8; r.l2 = 8'h65; end
            {4'd1, 7'h69}:  begin r.l1 = 8'hEC; r.l2 = 8'h69; end
            {4'd1, 7'h6F}:  begin r.l1 = 8'hF2; r.l2 = 8'h6F; end
            {4'd1, 7'h75}:  begin r.l1 = 8'hF9; r.l2 = 8'h75; end
            {4'd1, 7'h41}:  begin r.l1 = 8'hC0; r.l2 = 8'h41; end
            {4'd1, 7'h45}:  begin r.l1 = 8'hC8; r.l2 = 8'h45; end
            {4'd1, 7'h49}:  begin r.l1 = 8'hCC; r.l2 = 8'h49; end
            {4'd1, 7'h4F}:  begin r.l1 = 8'hD2; r.l2 = 8'h4F; end
            {4'd1, 7'h55}:  begin r.l1 = 8'hD9; r.l2 = 8'h55; end
            {4'd2, 7'h20}:  begin r.l1 = 8'h27; r.l2 = 8'h27; end
            {4'd2, 7'h61}:  begin r.l1 = 8'hE1; r.l2 = 8'hE1; end
            {4'd2, 7'h63}:  begin r.l1 = 8'h63; r.l2 = 8'hE6; end
            {4'd2, 7'h65}:  begin r.l1 = 8'hE9; r.l2 = 8'hE9; end
            {4'd2, 7'h69}:  begin r.l1 = 8'hED; r.l2 = 8'hED; end
            {4'd2, 7'h6C}:  begin r.l1 = 8'h6C; r.l2 = 8'hE5; end
            {4'd2, 7'h6E}:  begin r.l1 = 8'h6E; r.l2 = 8'hF1; end
            {4'd2, 7'h6F}:  begin r.l1 = 8'hF3; r.l2 = 8'hF3; end
            {4'd2, 7'h72}:  begin r.l1 = 8'h72; r.l2 = 8'hE0; end
            {4'd2, 7'h73}:  begin r.l1 = 8'h73; r.l2 = 8'hB6; end
            {4'd2, 7'h75}:  begin r.l1 = 8'hFA; r.l2 = 8'hFA; end
            {4'd2, 7'h79}:  begin r.l1 = 8'hFD; r.l2 = 8'hFD; end
            {4'd2, 7'h7A}:  begin r.l1 = 8'h7A; r.l2 = 8'hBC; end
            {4'd2, 7'h41}:  begin r.l1 = 8'hC1; r.l2 = 8'hC1; end
            {4'd2, 7'h43}:  begin r.l1 = 8'h43; r.l2 = 8'hC6; end
            {4'd2, 7'h45}:  begin r.l1 = 8'hC9; r.l2 = 8'hC9; end
            {4'd2, 7'h49}:  begin r.l1 = 8'hCD; r.l2 = 8'hCD; end
            {4'd2, 7'h4C}:  begin r.l1 = 8'h4C; r.l2 = 8'hC5; end
            {4'd2, 7'h4E}:  begin r.l1 = 8'h4E; r.l2 = 8'hD1; end
            {4'd2, 7'h4F}:  begin r.l1 = 8'hD3; r.l2 = 8'hD3; end
            {4'd2, 7'h52}:  begin r.l1 = 8'h52; r.l2 = 8'hC0; end
            {4'd2, 7'h53}:  begin r.l1 = 8'h53; r.l2 = 8'hA6; end
            {4'd2, 7'h55}:  begin r.l1 = 8'hDA; r.l2 = 8'hDA; end
            {4'd2, 7'h59}:  begin r.l1 = 8'hDD; r.l2 = 8'hDD; end
            {4'd2, 7'h5A}:  begin r.l1 = 8'h5A; r.l2 = 8'hAC; end
            {4'd3, 7'h20}:  begin r.l1 = 8'h5E; r.l2 = 8'h5E; end
            {4'd3, 7'h61}:  begin r.l1 = 8'hE2; r.l2 = 8'hE2; end
            {4'd3, 7'h65}:  begin r.l1 = 8'hEA; r.l2 = 8'h65; end
            {4'd3, 7'h69}:  begin r.l1 = 8'hEE; r.l2 = 8'hEE; end
            {4'd3, 7'h6F}:  begin r.l1 = 8'hF4; r.l2 = 8'hF4; end
            {4'd3, 7'h75}:  begin r.l1 = 8'hFB; r.l2 = 8'h75; end
            {4'd3, 7'h41}:  begin r.l1 = 8'hC2; r.l2 = 8'hC2; end
            {4'd3, 7'h45}:  begin r.l1 = 8'hCA; r.l2 = 8'h45; end
            {4'd3, 7'h49}:  begin r.l1 = 8'hCE; r.l2 = 8'hCE; end
            {4'd3, 7'h4F}:  begin r.l1 = 8'hD4; r.l2 = 8'hD4; end
            {4'd3, 7'h55}:  begin r.l1 = 8'hDB; r.l2 = 8'h55; end
            {4'd4, 7'h20}:  begin r.l1 = 8'h7E; r.l2 = 8'h7E; end
            {4'd4, 7'h61}:  begin r.l1 = 8'hE3; r.l2 = 8'h61; end
            {4'd4, 7'h6E}:  begin r.l1 = 8'hF1; r.l2 = 8'h6E; end
            {4'd4, 7'h6F}:  begin r.l1 = 8'hF5; r.l2 = 8'h6F; end
            {4'd4, 7'h41}:  begin r.l1 = 8'hC3; r.l2 = 8'h41; end
            {4'd4, 7'h4E}:  begin r.l1 = 8'hD1; r.l2 = 8'h4E; end
            {4'd4, 7'h4F}:  begin r.l1 = 8'hD5; r.l2 = 8'h4F; end
            {4'd6, 7'h61}:  begin r.l1 = 8'h61; r.l2 = 8'hE3; end
            {4'd6, 7'h41}:  begin r.l1 = 8'h41; r.l2 = 8'hC3; end
            {4'd7, 7'h7A}:  begin r.l1 = 8'h7A; r.l2 = 8'hBF; end
            {4'd7, 7'h5A}:  begin r.l1 = 8'h5A; r.l2 = 8'hAF; end
            {4'd8, 7'h61}:  begin r.l1 = 8'hE4; r.l2 = 8'hE4; end
            {4'd8, 7'h65}:  begin r.l1 = 8'hEB; r.l2 = 8'hEB; end
            {4'd8, 7'h69}:  begin r.l1 = 8'hEF; r.l2 = 8'h69; end
            {4'd8, 7'h6F}:  begin r.l1 = 8'hF6; r.l2 = 8'hF6; end
            {4'd8, 7'h75}:  begin r.l1 = 8'hFC; r.l2 = 8'hFC; end
            {4'd8, 7'h41}:  begin r.l1 = 8'hC4; r.l2 = 8'hC4; end
            {4'd8, 7'h45}:  begin r.l1 = 8'hCB; r.l2 = 8'hCB; end
            {4'd8, 7'h49}:  begin r.l1 = 8'hCF; r.l2 = 8'h49; end
            {4'd8, 7'h4F}:  begin r.l1 = 8'hD6; r.l2 = 8'hD6; end
            {4'd8, 7'h55}:  begin r.l1 = 8'hDC; r.l2 = 8'hDC; end
            {4'd10, 7'h20}: begin r.l1 = 8'hB0; r.l2 = 8'hB0; end
            {4'd10, 7'h61}: begin r.l1 = 8'hE5; r.l2 = 8'h61; end
            {4'd10, 7'h75}: begin r.l1 = 8'h75; r.l2 = 8'hF9; end
            {4'd10, 7'h41}: begin r.l1 = 8'hC5; r.l2 = 8'h41; end
            {4'd10, 7'h55}: begin r.l1 = 8'h55; r.l2 = 8'hD9; end
            {4'd11, 7'h63}: begin r.l1 = 8'hE7; r.l2 = 8'hE7; end
            {4'd11, 7'h73}: begin r.l1 = 8'h73; r.l2 = 8'hBA; end
            {4'd11, 7'h74}: begin r.l1 = 8'h74; r.l2 = 8'hFE; end
            {4'd11, 7'h43}: begin r.l1 = 8'hC7; r.l2 = 8'hC7; end
            {4'd11, 7'h53}: begin r.l1 = 8'h53; r.l2 = 8'hAA; end
            {4'd11, 7'h54}: begin r.l1 = 8'h54; r.l2 = 8'hDE; end
            {4'd12, 7'h20}: begin r.l1 = 8'h5F; r.l2 = 8'h5F; end
            {4'd13, 7'h20}: begin r.l1 = 8'h22; r.l2 = 8'h22; end
            {4'd13, 7'h6F}: begin r.l1 = 8'h6F; r.l2 = 8'hF5; end
            {4'd13, 7'h75}: begin r.l1 = 8'h75; r.l2 = 8'hFB; end
            {4'd13, 7'h4F}: begin r.l1 = 8'h4F; r.l2 = 8'hD5; end
            {4'd13, 7'h55}: begin r.l1 = 8'h55; r.l2 = 8'hDB; end
            {4'd14, 7'h61}: begin r.l1 = 8'h61; r.l2 = 8'hB1; end
            {4'd14, 7'h65}: begin r.l1 = 8'h65; r.l2 = 8'hEA; end
            {4'd14, 7'h41}: begin r.l1 = 8'h41; r.l2 = 8'hA1; end
            {4'd14, 7'h45}: begin r.l1 = 8'h45; r.l2 = 8'hCA; end
            {4'd15, 7'h63}: begin r.l1 = 8'h63; r.l2 = 8'hE8; end
            {4'd15, 7'h64}: begin r.l1 = 8'h64; r.l2 = 8'hEF; end
            {4'd15, 7'h65}: begin r.l1 = 8'h65; r.l2 = 8'hEC; end
            {4'd15, 7'h6C}: begin r.l1 = 8'h6C; r.l2 = 8'hB5; end
            {4'd15, 7'h6E}: begin r.l1 = 8'h6E; r.l2 = 8'hF2; end
            {4'd15, 7'h72}: begin r.l1 = 8'h72; r.l2 = 8'hF8; end
            {4'd15, 7'h73}: begin r.l1 = 8'h73; r.l2 = 8'hB9; end
            {4'd15, 7'h74}: begin r.l1 = 8'h74; r.l2 = 8'hBB; end
            {4'd15, 7'h7A}: begin r.l1 = 8'h7A; r.l2 = 8'hBE; end
            {4'd15, 7'h43}: begin r.l1 = 8'h43; r.l2 = 8'hC8; end
            {4'd15, 7'h44}: begin r.l1 = 8'h44; r.l2 = 8'hCF; end
            {4'd15, 7'h45}: begin r.l1 = 8'h45; r.l2 = 8'hCC; end
            {4'd15, 7'h4C}: begin r.l1 = 8'h4C; r.l2 = 8'hA5; end
            {4'd15, 7'h4E}: begin r.l1 = 8'h4E; r.l2 = 8'hD2; end
            {4'd15, 7'h52}: begin r.l1 = 8'h52; r.l2 = 8'hD8; end
            {4'd15, 7'h53}: begin r.l1 = 8'h53; r.l2 = 8'hA9; end
            {4'd15, 7'h54}: begin r.l1 = 8'h54; r.l2 = 8'hAB; end
            {4'd15, 7'h5A}: begin r.l1 = 8'h5A; r.l2 = 8'hAE; end
            default:        r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> src/teletext_enhancement_triplet_decoder_top.sv
// Channel    Direction  Handshake                    Payload
// item       in         item_valid / item_ready      item_t: cmd, triplet
// result     out        result_valid / result_ready  result_t: row, column, char_code
// config     in         APB psel/penable/pwrite      charset_latin1 at address 0
//
// A word is taken into the input register and decoded there combinationally; a
// character write lands in the result register on the next edge, and one word
// can be taken every cycle while the result is not stalled.
// Reset clears both valid flags, sets the active row to 0 and selects Latin-1.
// A stalled result only stops the input register when that register is full.
module teletext_enhancement_triplet_decoder_top
    import tted_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Input register: the word under decode.
    logic             in_vld_reg;
    logic             in_vld_next;
    item_t            in_word_reg;

    // Result register.
    logic             out_vld_reg;
    logic             out_vld_next;
    result_t          out_word_reg;

    // Page state: the row that column triplets write into.
    logic [ROW_W-1:0] active_row_reg;
    logic [ROW_W-1:0] active_row_next;

    logic             charset_latin1;
    dec_ctl_t         dec_ctl;
    result_t          dec_result;
    logic             advance;
    logic             fire;

    tted_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .charset_latin1 (charset_latin1)
    );

    tted_decode u_decode (
        .item           (in_word_reg),
        .active_row     (active_row_reg),
        .charset_latin1 (charset_latin1),
        .ctl            (dec_ctl),
        .result         (dec_result)
    );

    assign pready = 1'b1;

    // The result register can take a new value when it is empty or being read.
    // The decoded word leaves the input register whenever that holds, whether
    // or not it produces a character write.
    assign advance    = !out_vld_reg || result_ready;
    assign fire       = in_vld_reg && advance;
    assign item_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (item_ready)
        begin
            in_vld_next = item_valid;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = fire && dec_ctl.wr;
        end
    end

    // Row updates take effect as the word leaves, so the next word sees them.
    always_comb
    begin
        active_row_next = active_row_reg;
        if (fire && dec_ctl.row_we)
        begin
            active_row_next = dec_ctl.row_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            active_row_reg <= '0;
        end
        else
        begin
            in_vld_reg     <= in_vld_next;
            out_vld_reg    <= out_vld_next;
            active_row_reg <= active_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_word_reg <= item;
        end
        if (fire && dec_ctl.wr)
        begin
            out_word_reg <= dec_result;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_word_reg;

    // A page start leaves the active row at the top.
    a_page_start_row: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_word_reg.cmd == CMD_PAGE_START |=> active_row_reg == '0)
        else $error("active row not cleared by page start");

    // Every result names a cell inside the page.
    a_result_in_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (32'(out_word_reg.row) < PAGE_HEIGHT)
                     && (32'(out_word_reg.column) < PAGE_WIDTH))
        else $error("result outside the page");

    // The active row never leaves the range a row triplet can set.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_row_reg <= ROW_BOTTOM)
        else $error("active row out of range");

    // Input is held off only when both registers are full and the output stalls.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_vld_reg && out_vld_reg && !result_ready)
        else $error("input stalled without a full pipeline");

    // A decoded write is never dropped: it is in the result register next cycle.
    a_write_kept: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec_ctl.wr |=> out_vld_reg)
        else $error("decoded write lost");

endmodule

>>> src/tted_cfg.sv
module tted_cfg
    import tted_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  charset_latin1
);

    logic charset_reg;
    logic charset_next;
    logic sel_charset;

    // Register index is the byte address divided by four.
    assign sel_charset = (paddr[2] == REG_CHARSET);

    always_comb
    begin
        charset_next = charset_reg;
        if (psel && penable && pwrite && sel_charset)
        begin
            charset_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charset_reg <= 1'b1;
        end
        else
        begin
            charset_reg <= charset_next;
        end
    end

    assign prdata         = sel_charset ? {{(CFG_DATA_W-1){1'b0}}, charset_reg} : '0;
    assign charset_latin1 = charset_reg;

endmodule

>>> src/tted_decode.sv
module tted_decode
    import tted_pkg::*;
(
    input  item_t            item,
    input  logic [ROW_W-1:0] active_row,
    input  logic             charset_latin1,
    output dec_ctl_t         ctl,
    output result_t          result
);

    logic [ADDR_W-1:0] adr;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data;
    logic              filler;
    logic              row_addr;
    logic [ROW_W-1:0]  row_target;
    logic [DATA_W-1:0] g2_idx;
    logic [CHAR_W-1:0] g2_code;
    mark_hit_t         mark;
    logic [CHAR_W-1:0] mark_code;
    logic              in_page;

    assign adr    = item.triplet[5:0];
    assign mode   = item.triplet[10:6];
    assign data   = item.triplet[17:11];
    assign filler = (item.triplet[10:0] == FILLER_PATTERN);

    assign row_addr   = (adr >= ROW_ADDR_BASE);
    // Address 40 names the bottom row; 41 to 63 name rows 1 to 23.
    assign row_target = (adr == ROW_ADDR_BASE) ? ROW_BOTTOM : ROW_W'(adr - ROW_ADDR_BASE);

    assign g2_idx  = data - G2_FIRST_CODE;
    assign g2_code = charset_latin1 ? G2_L1[g2_idx] : G2_L2[g2_idx];

    assign mark      = mark_lookup(mode[3:0], data);
    assign mark_code = !mark.hit ? {1'b0, data} : (charset_latin1 ? mark.l1 : mark.l2);

    assign in_page = (32'(adr) < PAGE_WIDTH) && (32'(active_row) < PAGE_HEIGHT);

    always_comb
    begin
        ctl = '{row_we: 1'b0, row_val: '0, wr: 1'b0};
        if (item.cmd == CMD_PAGE_START)
        begin
            ctl.row_we = 1'b1;
        end
        else if (!filler)
        begin
            if (row_addr)
            begin
                if (mode == MODE_SET_ROW_A || mode == MODE_SET_ROW_B)
                begin
                    ctl.row_we  = 1'b1;
                    ctl.row_val = row_target;
                end
                else if (mode == MODE_ROW_HOME && adr == ROW_ADDR_LAST)
                begin
                    ctl.row_we = 1'b1;
                end
            end
            else if (mode >= MODE_G2 && in_page)
            begin
                // A G2 code below the printable range writes nothing.
                ctl.wr = (mode != MODE_G2) || (data >= G2_FIRST_CODE);
            end
        end
    end

    assign result.row       = active_row;
    assign result.column    = adr;
    assign result.char_code = (mode == MODE_G2) ? g2_code : mark_code;

endmodule
